[src/cle_pkg.sv]
`default_nettype none
package cle_pkg;

  localparam int SLOT_COUNT_DEF = 1024;
  localparam int FIELD_W = 10;
  localparam int DATA_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_ALLOC2,
    S_WALK,
    S_SPLICE_A,
    S_SPLICE_B,
    S_RESULT
  } state_t;

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] list_length;
    logic [FIELD_W-1:0] slot_used;
  } result_t;

endpackage
`default_nettype wire

[src/cle_ram.sv]
`default_nettype none
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/cle_seq.sv]
`default_nettype none
module cle_seq #(
  parameter int SLOT_COUNT = cle_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         operation,
  input  wire logic [cle_pkg::FIELD_W-1:0]  position,
  input  wire logic [cle_pkg::DATA_W-1:0]   value,
  output logic                              res_valid,
  input  wire logic                         res_take,
  output cle_pkg::result_t                  res
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CMP_W = ((IW > cle_pkg::FIELD_W) ? IW : cle_pkg::FIELD_W) + 1;
  localparam int WALK_W = cle_pkg::FIELD_W + 1;
  localparam logic [IW-1:0] HEAD = IW'(SLOT_COUNT - 1);
  localparam logic [IW-1:0] LAST_FREE = IW'(SLOT_COUNT - 2);

  cle_pkg::state_t state, state_next;

  logic [IW-1:0] count;
  logic [IW-1:0] free_head;
  logic [IW-1:0] clr_idx;

  logic                        op;
  logic [cle_pkg::DATA_W-1:0]  val;
  cle_pkg::status_t            status;
  logic [IW-1:0]               used;
  logic [IW-1:0]               fresh;
  logic [IW-1:0]               cur;
  logic [IW-1:0]               prev;
  logic [WALK_W-1:0]           remaining;
  logic                        first;

  logic                        link_we;
  logic [IW-1:0]               link_waddr;
  logic [IW-1:0]               link_wdata;
  logic [IW-1:0]               link_raddr;
  logic [IW-1:0]               link_rdata;
  logic                        data_we;
  logic [cle_pkg::DATA_W-1:0]  data_rdata;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             ins_bad;
  logic             del_bad;
  logic             is_full;
  cle_pkg::status_t chk_status;

  cle_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  cle_ram #(.WIDTH(cle_pkg::DATA_W), .DEPTH(SLOT_COUNT)) u_data (
    .clk   (clk),
    .we    (data_we),
    .waddr (fresh),
    .wdata (val),
    .raddr (fresh),
    .rdata (data_rdata)
  );

  // position check against the current length, and free-slot check for insert
  always_comb begin
    pos_ext = CMP_W'(position);
    cnt_ext = CMP_W'(count);
    ins_bad = (position == '0) || (pos_ext > cnt_ext + CMP_W'(1));
    del_bad = (position == '0) || (pos_ext > cnt_ext);
    is_full = (free_head == '0);
    if (operation == cle_pkg::OP_INSERT) begin
      chk_status = ins_bad ? cle_pkg::ST_RANGE : (is_full ? cle_pkg::ST_FULL : cle_pkg::ST_OK);
    end else begin
      chk_status = del_bad ? cle_pkg::ST_RANGE : cle_pkg::ST_OK;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cle_pkg::S_CLEAR: begin
        if (clr_idx == HEAD) state_next = cle_pkg::S_IDLE;
      end
      cle_pkg::S_IDLE: begin
        if (in_valid) begin
          if (chk_status != cle_pkg::ST_OK) state_next = cle_pkg::S_RESULT;
          else if (operation == cle_pkg::OP_INSERT) state_next = cle_pkg::S_ALLOC;
          else state_next = cle_pkg::S_WALK;
        end
      end
      cle_pkg::S_ALLOC:    state_next = cle_pkg::S_ALLOC2;
      cle_pkg::S_ALLOC2:   state_next = cle_pkg::S_WALK;
      cle_pkg::S_WALK: begin
        if (remaining == WALK_W'(1)) state_next = cle_pkg::S_SPLICE_A;
      end
      cle_pkg::S_SPLICE_A: state_next = cle_pkg::S_SPLICE_B;
      cle_pkg::S_SPLICE_B: state_next = cle_pkg::S_RESULT;
      cle_pkg::S_RESULT: begin
        if (res_take) state_next = cle_pkg::S_IDLE;
      end
      default:             state_next = cle_pkg::S_IDLE;
    endcase
  end

  // memory port control and handshake outputs
  always_comb begin
    in_stall   = (state != cle_pkg::S_IDLE);
    res_valid  = (state == cle_pkg::S_RESULT);
    data_we    = (state == cle_pkg::S_ALLOC2);
    link_we    = 1'b0;
    link_waddr = cur;
    link_wdata = link_rdata;
    link_raddr = cur;
    case (state)
      cle_pkg::S_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_idx;
        link_wdata = (clr_idx < LAST_FREE) ? clr_idx + IW'(1) : '0;
      end
      cle_pkg::S_ALLOC: begin
        link_raddr = free_head;
      end
      cle_pkg::S_ALLOC2: begin
        link_raddr = fresh;
      end
      cle_pkg::S_WALK: begin
        link_raddr = first ? HEAD : link_rdata;
      end
      cle_pkg::S_SPLICE_A: begin
        link_we    = 1'b1;
        link_waddr = (op == cle_pkg::OP_INSERT) ? fresh : prev;
        link_wdata = link_rdata;
      end
      cle_pkg::S_SPLICE_B: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = (op == cle_pkg::OP_INSERT) ? fresh : free_head;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cle_pkg::S_CLEAR;
      count     <= '0;
      free_head <= IW'(1);
      clr_idx   <= '0;
    end else begin
      state <= state_next;
      case (state)
        cle_pkg::S_CLEAR:  clr_idx <= clr_idx + IW'(1);
        cle_pkg::S_ALLOC2: free_head <= link_rdata;
        cle_pkg::S_SPLICE_B: begin
          if (op == cle_pkg::OP_INSERT) begin
            count <= count + IW'(1);
          end else begin
            count     <= count - IW'(1);
            free_head <= cur;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cle_pkg::S_IDLE: begin
        if (in_valid) begin
          op        <= operation;
          val       <= value;
          status    <= chk_status;
          used      <= '0;
          first     <= 1'b1;
          remaining <= (operation == cle_pkg::OP_DELETE) ? WALK_W'(position) + WALK_W'(1)
                                                         : WALK_W'(position);
        end
      end
      cle_pkg::S_ALLOC: fresh <= free_head;
      cle_pkg::S_WALK: begin
        first     <= 1'b0;
        prev      <= cur;
        cur       <= link_raddr;
        remaining <= remaining - WALK_W'(1);
      end
      cle_pkg::S_SPLICE_B: begin
        used <= (op == cle_pkg::OP_INSERT) ? fresh : cur;
      end
      default: begin
        first <= first;
      end
    endcase
  end

  always_comb begin
    res.status      = status;
    res.list_length = cle_pkg::FIELD_W'(count);
    res.slot_used   = cle_pkg::FIELD_W'(used);
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= LAST_FREE)
    else $error("list length above capacity");

  a_walk_live: assert property (@(posedge clk) disable iff (rst)
    state == cle_pkg::S_WALK |-> remaining != '0)
    else $error("walk entered with nothing to read");

  a_fresh_slot: assert property (@(posedge clk) disable iff (rst)
    (state == cle_pkg::S_SPLICE_A && op == cle_pkg::OP_INSERT) |->
      (fresh != '0 && fresh != HEAD))
    else $error("insert took a header slot");

  a_data_kept: assert property (@(posedge clk) disable iff (rst)
    (state == cle_pkg::S_SPLICE_A && op == cle_pkg::OP_INSERT) |-> data_rdata == val)
    else $error("stored value lost");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == cle_pkg::S_IDLE && in_valid) |=> state != cle_pkg::S_IDLE)
    else $error("transfer taken without starting work");
`endif

endmodule
`default_nettype wire

[src/cursor_linked_list_engine.sv]
// Ordered list of 32-bit values held in SLOT_COUNT slots joined by links.
// Input channel (in_valid / in_stall): operation 0 inserts value at the
// 1-based position, 1 deletes the element at position. One transfer in
// gives exactly one transfer out.
// Output channel (out_valid / out_stall): status (0 ok, 1 bad position,
// 2 no free slot), list_length after the item, slot_used (0 on error).
// After reset the link memory is initialized one slot per cycle; in_stall
// stays high during that pass. An insert goes through two allocation
// states, a walk to the position and two splice states to the result; a
// delete walks one step further, then splices; a rejected item goes to the
// result directly. One item is worked at a time; each walk step is one
// read of the link memory. The result sits in an output register; while
// out_stall is high it holds, and a finished item waits in the sequencer
// until the register is free, before the next is started.
`default_nettype none
module cursor_linked_list_engine #(
  parameter int SLOT_COUNT = cle_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         operation,
  input  wire logic [cle_pkg::FIELD_W-1:0]  position,
  input  wire logic [cle_pkg::DATA_W-1:0]   value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        status,
  output logic [cle_pkg::FIELD_W-1:0]       list_length,
  output logic [cle_pkg::FIELD_W-1:0]       slot_used
);

  logic             res_valid;
  logic             res_take;
  cle_pkg::result_t res;

  cle_seq #(.SLOT_COUNT(SLOT_COUNT)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .position  (position),
    .value     (value),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status      <= res.status;
      list_length <= res.list_length;
      slot_used   <= res.slot_used;
    end
  end

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

  localparam int FW = cle_pkg::FIELD_W;
  localparam int DW = cle_pkg::DATA_W;
  localparam int SLOTS = cle_pkg::SLOT_COUNT_DEF;
  localparam int FREE_HEAD = 0;
  localparam int LIST_HEAD = SLOTS - 1;
  localparam longint CYCLE_LIMIT = 12_000_000;
  localparam int MAX_REPORTS = 10;

  logic           clk;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic           operation = cle_pkg::OP_INSERT;
  logic [FW-1:0]  position = '0;
  logic [DW-1:0]  value = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [1:0]     status;
  logic [FW-1:0]  list_length;
  logic [FW-1:0]  slot_used;

  cursor_linked_list_engine u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .list_length (list_length),
    .slot_used   (slot_used)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // shadow of the link memory and element count
  logic [FW-1:0]     link_mem [SLOTS];
  int                elem_cnt;
  cle_pkg::result_t  pending_q [$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  err_cnt = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_full = 0;
  int  n_range = 0;
  int  peak_len = 0;
  longint cyc = 0;

  typedef struct packed {
    logic           op;
    logic [FW-1:0]  pos;
    logic [DW-1:0]  val;
    logic           typed;
    logic [1:0]     st;
    logic [FW-1:0]  len;
    logic [FW-1:0]  slot;
  } dir_row_t;

  localparam int DIR_N = 21;
  dir_row_t dir_rows [DIR_N] = '{
    '{cle_pkg::OP_DELETE, 10'd1,    32'hffff_ffff, 1'b1, cle_pkg::ST_RANGE, 10'd0, 10'd0},
    '{cle_pkg::OP_INSERT, 10'd0,    32'h0000_0000, 1'b1, cle_pkg::ST_RANGE, 10'd0, 10'd0},
    '{cle_pkg::OP_INSERT, 10'd2,    32'h0000_0000, 1'b1, cle_pkg::ST_RANGE, 10'd0, 10'd0},
    '{cle_pkg::OP_INSERT, 10'd1,    32'h8000_0000, 1'b1, cle_pkg::ST_OK,    10'd1, 10'd1},
    '{cle_pkg::OP_INSERT, 10'd2,    32'h7fff_ffff, 1'b1, cle_pkg::ST_OK,    10'd2, 10'd2},
    '{cle_pkg::OP_INSERT, 10'd1,    32'hffff_ffff, 1'b1, cle_pkg::ST_OK,    10'd3, 10'd3},
    '{cle_pkg::OP_INSERT, 10'd1023, 32'h0000_0001, 1'b1, cle_pkg::ST_RANGE, 10'd3, 10'd0},
    '{cle_pkg::OP_DELETE, 10'd0,    32'h0000_0000, 1'b1, cle_pkg::ST_RANGE, 10'd3, 10'd0},
    '{cle_pkg::OP_DELETE, 10'd4,    32'h0000_0000, 1'b1, cle_pkg::ST_RANGE, 10'd3, 10'd0},
    '{cle_pkg::OP_DELETE, 10'd1023, 32'hffff_ffff, 1'b1, cle_pkg::ST_RANGE, 10'd3, 10'd0},
    '{cle_pkg::OP_INSERT, 10'd4,    32'ha5a5_a5a5, 1'b1, cle_pkg::ST_OK,    10'd4, 10'd4},
    '{cle_pkg::OP_DELETE, 10'd2,    32'h5a5a_5a5a, 1'b0, cle_pkg::ST_OK,    10'd0, 10'd0},
    '{cle_pkg::OP_INSERT, 10'd3,    32'h5a5a_5a5a, 1'b0, cle_pkg::ST_OK,    10'd0, 10'd0},
    '{cle_pkg::OP_DELETE, 10'd5,    32'h0000_0000, 1'b1, cle_pkg::ST_RANGE, 10'd4, 10'd0},
    '{cle_pkg::OP_DELETE, 10'd4,    32'h0000_0000, 1'b0, cle_pkg::ST_OK,    10'd0, 10'd0},
    '{cle_pkg::OP_INSERT, 10'd1,    32'h0000_0000, 1'b0, cle_pkg::ST_OK,    10'd0, 10'd0},
    '{cle_pkg::OP_DELETE, 10'd1,    32'h0000_0000, 1'b0, cle_pkg::ST_OK,    10'd0, 10'd0},
    '{cle_pkg::OP_DELETE, 10'd1,    32'h0000_0000, 1'b0, cle_pkg::ST_OK,    10'd0, 10'd0},
    '{cle_pkg::OP_DELETE, 10'd1,    32'h0000_0000, 1'b0, cle_pkg::ST_OK,    10'd0, 10'd0},
    '{cle_pkg::OP_DELETE, 10'd1,    32'h0000_0000, 1'b0, cle_pkg::ST_OK,    10'd0, 10'd0},
    '{cle_pkg::OP_INSERT, 10'd1,    32'h1234_5678, 1'b0, cle_pkg::ST_OK,    10'd0, 10'd0}
  };

  function automatic int prev_slot_of(input int pos);
    int cur;
    cur = LIST_HEAD;
    for (int n = 1; n < pos; n++) cur = link_mem[cur];
    return cur;
  endfunction

  function automatic cle_pkg::result_t apply_list_op(input logic op,
                                                     input logic [FW-1:0] pos);
    cle_pkg::result_t r;
    int               prev;
    int               fresh;
    int               gone;
    r.status = cle_pkg::ST_OK;
    r.slot_used = '0;
    if (op == cle_pkg::OP_INSERT) begin
      if (pos == 0 || int'(pos) > elem_cnt + 1) begin
        r.status = cle_pkg::ST_RANGE;
      end else begin
        fresh = link_mem[FREE_HEAD];
        if (fresh == 0) begin
          r.status = cle_pkg::ST_FULL;
        end else begin
          link_mem[FREE_HEAD] = link_mem[fresh];
          prev = prev_slot_of(pos);
          link_mem[fresh] = link_mem[prev];
          link_mem[prev] = FW'(fresh);
          elem_cnt++;
          r.slot_used = FW'(fresh);
        end
      end
    end else begin
      if (pos == 0 || int'(pos) > elem_cnt) begin
        r.status = cle_pkg::ST_RANGE;
      end else begin
        prev = prev_slot_of(pos);
        gone = link_mem[prev];
        link_mem[prev] = link_mem[gone];
        link_mem[gone] = link_mem[FREE_HEAD];
        link_mem[FREE_HEAD] = FW'(gone);
        elem_cnt--;
        r.slot_used = FW'(gone);
      end
    end
    r.list_length = FW'(elem_cnt);
    return r;
  endfunction

  task automatic send_item(input logic op, input logic [FW-1:0] pos,
                           input logic [DW-1:0] val, input bit typed,
                           input cle_pkg::result_t typed_res);
    cle_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    r = apply_list_op(op, pos);
    pending_q.push_back(typed ? typed_res : r);
    n_sent++;
    if (elem_cnt > peak_len) peak_len = elem_cnt;
  endtask

  task automatic run_random(input int count, input int lo_len, input int hi_len);
    logic           op;
    logic [FW-1:0]  pos;
    int             lim;
    int             far;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 12) begin
        op = logic'($urandom_range(1));
        case ($urandom_range(3))
          0: pos = '0;
          1: pos = '1;
          default: begin
            far = (op == cle_pkg::OP_INSERT ? elem_cnt + 2 : elem_cnt + 1) +
                  $urandom_range(40);
            pos = (far > 1023) ? '1 : FW'(far);
          end
        endcase
      end else begin
        if (elem_cnt == 0) op = cle_pkg::OP_INSERT;
        else if (elem_cnt >= hi_len) op = cle_pkg::OP_DELETE;
        else if (elem_cnt < lo_len) op = cle_pkg::OP_INSERT;
        else op = logic'($urandom_range(1));
        lim = (op == cle_pkg::OP_INSERT) ? elem_cnt + 1 : elem_cnt;
        case ($urandom_range(3))
          0: pos = 10'd1;
          1: pos = FW'(lim);
          default: pos = FW'($urandom_range(lim, 1));
        endcase
      end
      send_item(op, pos, $urandom, 1'b0, '0);
    end
  endtask

  function automatic cle_pkg::result_t mk_res(input cle_pkg::status_t st, input int len,
                                              input int slot);
    cle_pkg::result_t r;
    r.status = st;
    r.list_length = FW'(len);
    r.slot_used = FW'(slot);
    return r;
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cle_pkg::result_t exp_r;
    cle_pkg::result_t got;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.status = cle_pkg::status_t'(status);
      got.list_length = list_length;
      got.slot_used = slot_used;
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected result: status %0d len %0d slot %0d",
                   got.status, got.list_length, got.slot_used);
      end else begin
        exp_r = pending_q.pop_front();
        n_checked++;
        if (got.status == cle_pkg::ST_FULL) n_full++;
        if (got.status == cle_pkg::ST_RANGE) n_range++;
        if (got.status !== exp_r.status || got.list_length !== exp_r.list_length ||
            got.slot_used !== exp_r.slot_used) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display({"mismatch on result %0d: expected st %0d len %0d slot %0d, ",
                      "got st %0d len %0d slot %0d"},
                     n_checked, exp_r.status, exp_r.list_length, exp_r.slot_used,
                     got.status, got.list_length, got.slot_used);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc, pending_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < SLOTS - 2; s++) link_mem[s] = FW'(s + 1);
    link_mem[SLOTS - 2] = '0;
    link_mem[LIST_HEAD] = '0;
    elem_cnt = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val, dir_rows[i].typed,
                mk_res(cle_pkg::status_t'(dir_rows[i].st), dir_rows[i].len,
                       dir_rows[i].slot));
    end

    send_idle_pct = 0;  recv_stall_pct = 0;  run_random(135, 0, 48);
    send_idle_pct = 54; recv_stall_pct = 0;  run_random(135, 0, 48);
    send_idle_pct = 0;  recv_stall_pct = 54; run_random(135, 0, 48);
    send_idle_pct = 32; recv_stall_pct = 32; run_random(135, 0, 48);
    run_random(20, 0, 8);

    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SLOTS + 32) @(posedge clk);

    $display("%0d transfers in, %0d results checked (%0d out of range, %0d full rejects)",
             n_sent, n_checked, n_range, n_full);
    $display("longest list held %0d elements, sender and receiver gaps mixed, %0d cycles",
             peak_len, cyc);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", err_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
